// ===== design/srpq_pkg.sv =====
// Shared types and codes for the sorted ring priority queue.
// No dependencies; imported by the cell and the top level.
package srpq_pkg;

  localparam int KEY_W = 16;
  localparam int PAY_W = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic valid;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } slot_t;

  typedef struct packed {
    logic en;
    logic cmd;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } op_t;

endpackage

// ===== design/sorted_ring_priority_queue.sv =====
// Top level of the sorted priority queue: a chain of SLOTS-1 compare/shift
// cells, an occupancy counter and a result register. Depends on srpq_pkg, srpq_cell.
//
//  channel | ports                                               | dir
//  --------+-----------------------------------------------------+----
//  in      | in_valid in_ready in_command in_insert_key/payload  | in
//  out     | out_valid out_ready out_status out_key out_payload  | out
//          | out_occupancy                                       |
//
// One beat per cycle: every cell compares and shifts in parallel in the cycle
// the beat is accepted, and the result lands in the output register next edge.
// A new beat is taken while a result waits only if out_ready takes it that cycle.
// Reset empties the chain by clearing the cell valid bits; no clearing pass.
module sorted_ring_priority_queue
  import srpq_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [KEY_W-1:0]    in_insert_key,
  input  logic [PAY_W-1:0]    in_insert_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [KEY_W-1:0]    out_key,
  output logic [PAY_W-1:0]    out_payload,
  output logic [OCC_W-1:0]    out_occupancy
);

  localparam int CELLS = SLOTS - 1;
  localparam int CW = $clog2(SLOTS);

  logic accept;
  logic full, empty;
  op_t  op;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] count_wide;

  logic out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;
  logic [OCC_W-1:0] occ_r;

  slot_t slots [CELLS];
  logic  keeps [CELLS];

  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;
  assign full = (count_r == CW'(CELLS));
  assign empty = (count_r == '0);

  always_comb begin
    op.cmd = in_command;
    op.key = in_insert_key;
    op.payload = in_insert_payload;
    op.en = accept && ((in_command == CMD_INSERT) ? !full : !empty);
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    slot_t prev_s, next_s;
    logic  prev_k;
    if (i == 0) begin : g_first
      assign prev_s = '0;
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_s = slots[i-1];
      assign prev_k = keeps[i-1];
    end
    if (i == CELLS - 1) begin : g_last
      assign next_s = '0;
    end else begin : g_inner
      assign next_s = slots[i+1];
    end
    srpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .prev_slot (prev_s),
      .prev_keep (prev_k),
      .next_slot (next_s),
      .slot      (slots[i]),
      .keep      (keeps[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    status_nxt = ST_INSERTED;
    key_nxt = '0;
    pay_nxt = '0;
    if (in_command == CMD_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_REMOVED;
        key_nxt = slots[0].key;
        pay_nxt = slots[0].payload;
        count_nxt = count_r - CW'(1);
      end
    end
  end

  assign count_wide = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      key_r <= key_nxt;
      pay_r <= pay_nxt;
      occ_r <= count_wide[OCC_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_key = key_r;
  assign out_payload = pay_r;
  assign out_occupancy = occ_r;

endmodule

// ===== design/srpq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it with the new key,
// and takes the new entry or a neighbor's entry. Depends on srpq_pkg.
module srpq_cell
  import srpq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  op_t   op,
  input  slot_t prev_slot,
  input  logic  prev_keep,
  input  slot_t next_slot,
  output slot_t slot,
  output logic  keep
);

  logic valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;

  // Keep the entry on insert when it sorts ahead of the new key (ties stay ahead).
  assign keep = valid_r && (key_r >= op.key);
  assign slot = '{valid: valid_r, key: key_r, payload: pay_r};

  always_comb begin
    valid_nxt = valid_r;
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (op.en) begin
      if (op.cmd == CMD_REMOVE) begin
        valid_nxt = next_slot.valid;
        key_nxt = next_slot.key;
        pay_nxt = next_slot.payload;
      end else if (!keep) begin
        if (prev_keep) begin
          valid_nxt = 1'b1;
          key_nxt = op.key;
          pay_nxt = op.payload;
        end else begin
          valid_nxt = prev_slot.valid;
          key_nxt = prev_slot.key;
          pay_nxt = prev_slot.payload;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

endmodule

// ===== sim/sorted_ring_priority_queue_tb.sv =====
// Testbench for sorted_ring_priority_queue: drives insert/remove beats, predicts each
// result from a sorted copy of the stored entries and checks every output beat.
// Depends on srpq_pkg and the sorted_ring_priority_queue RTL.
`timescale 1ns / 100ps

module sorted_ring_priority_queue_tb;
  import srpq_pkg::*;

  localparam int SLOTS = 16;
  localparam int CAPACITY = SLOTS - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [PAY_W-1:0]    payload;
    logic [OCC_W-1:0]    occupancy;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_command = CMD_INSERT;
  logic [KEY_W-1:0]    in_insert_key = '0;
  logic [PAY_W-1:0]    in_insert_payload = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_key;
  logic [PAY_W-1:0]    out_payload;
  logic [OCC_W-1:0]    out_occupancy;

  entry_t   sorted_entries[$];
  outcome_t pending_outcomes[$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       rx_hold_cycles = 0;
  bit       sender_idle = 1'b0;
  bit       receiver_idle = 1'b0;

  sorted_ring_priority_queue #(
    .SLOTS(SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_insert_key    (in_insert_key),
    .in_insert_payload(in_insert_payload),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_key          (out_key),
    .out_payload      (out_payload),
    .out_occupancy    (out_occupancy)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap(input bit enable);
    int roll;
    if (!enable) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input int mode);
    case (mode)
      0: begin
        return KEY_W'($urandom_range(0, 3));
      end
      1: begin
        return KEY_W'(16'hFFFF - $urandom_range(0, 3));
      end
      2: begin
        return KEY_W'($urandom_range(0, 7) << 13);
      end
      default: begin
        return KEY_W'($urandom);
      end
    endcase
  endfunction

  // Apply one accepted beat to the sorted copy and queue the outcome.
  task automatic predict_outcome(input logic cmd, input logic [KEY_W-1:0] key,
                                 input logic [PAY_W-1:0] pay);
    outcome_t res;
    entry_t   ent;
    int       pos;
    res.key = '0;
    res.payload = '0;
    if (cmd == CMD_INSERT) begin
      if (sorted_entries.size() == CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_entries.size() && !(sorted_entries[pos].key < key)) begin
          pos++;
        end
        ent.key = key;
        ent.payload = pay;
        sorted_entries.insert(pos, ent);
        res.status = ST_INSERTED;
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        ent = sorted_entries.pop_front();
        res.key = ent.key;
        res.payload = ent.payload;
        res.status = ST_REMOVED;
      end
    end
    res.occupancy = OCC_W'(sorted_entries.size());
    pending_outcomes.push_back(res);
  endtask

  // Start at a rising edge; return at the edge that accepts the beat.
  task automatic send_beat(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay);
    int   gap;
    logic taken;
    gap = pick_gap(sender_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_insert_key <= key;
    in_insert_payload <= pay;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (in_ready) begin
        taken = 1'b1;
        predict_outcome(cmd, key, pay);
      end
      @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_outcomes.size() != 0);
  endtask

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
      error_count++;
    end
  endtask

  always @(negedge clk) begin
    outcome_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got status %0d key %0d",
                 $time, out_status, out_key);
        error_count++;
      end else begin
        exp_res = pending_outcomes.pop_front();
        check_field("status", exp_res.status, out_status);
        check_field("key", exp_res.key, out_key);
        check_field("payload", exp_res.payload, out_payload);
        check_field("occupancy", exp_res.occupancy, out_occupancy);
      end
    end
  end

  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = pick_gap(receiver_idle);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        for (int held = 0; held < gap; held++) begin
          @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic test_directed();
    int n;
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    send_beat(CMD_REMOVE, 16'hFFFF, 16'hFFFF);
    send_beat(CMD_INSERT, 16'h8000, 16'h0001);
    send_beat(CMD_INSERT, 16'hFFFF, 16'hFFFF);
    send_beat(CMD_INSERT, 16'h0000, 16'h0000);
    send_beat(CMD_INSERT, 16'h8000, 16'h0002);
    send_beat(CMD_INSERT, 16'h8000, 16'h0003);
    send_beat(CMD_INSERT, 16'h7FFF, 16'h1234);
    send_beat(CMD_INSERT, 16'h8001, 16'hABCD);
    for (n = 1; n <= 8; n++) begin
      send_beat(CMD_INSERT, KEY_W'(n * 16'h0010), PAY_W'(16'h5A00 + n));
    end
    send_beat(CMD_INSERT, 16'h4000, 16'hDEAD);
    for (n = 0; n < 8; n++) begin
      send_beat(CMD_REMOVE, 16'h0000, 16'h0000);
    end
  endtask

  task automatic test_random_mix(input int beats);
    int   n;
    int   insert_pct;
    int   key_mode;
    logic cmd;
    insert_pct = 50;
    key_mode = 3;
    for (n = 0; n < beats; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            insert_pct = 15;
          end
          1: begin
            insert_pct = 50;
          end
          2: begin
            insert_pct = 75;
          end
          default: begin
            insert_pct = 95;
          end
        endcase
        key_mode = $urandom_range(0, 5);
        sender_idle = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
      end
      cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      send_beat(cmd, pick_key(key_mode), PAY_W'($urandom));
    end
  endtask

  task automatic test_fill_and_empty(input int rounds);
    int r;
    int n;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    for (r = 0; r < rounds; r++) begin
      for (n = 0; n < CAPACITY + 3; n++) begin
        send_beat(CMD_INSERT, pick_key(r % 4), PAY_W'($urandom));
      end
      for (n = 0; n < CAPACITY + 3; n++) begin
        send_beat(CMD_REMOVE, KEY_W'($urandom), PAY_W'($urandom));
      end
    end
  endtask

  task automatic test_backpressure(input int hold, input int beats);
    int n;
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    rx_hold_cycles = hold;
    for (n = 0; n < beats; n++) begin
      send_beat($urandom_range(0, 1) ? CMD_INSERT : CMD_REMOVE, pick_key(3),
                PAY_W'($urandom));
    end
  endtask

  task automatic test_drain_pause(input int rounds, input int beats);
    int r;
    for (r = 0; r < rounds; r++) begin
      sender_idle = r[0];
      receiver_idle = r[1];
      test_random_mix(beats);
      wait_drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(1450);
    test_fill_and_empty(6);
    test_backpressure(80, 40);
    test_backpressure(120, 40);
    test_drain_pause(8, 30);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
